>>> src/byte_pattern_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the byte pattern search block.
// ----------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SEARCH_MACROS_SVH
`define BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every clk_i edge outside reset.
`define BPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk_i edge outside reset.
`define BPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bpsrch_pkg.sv
// ----------------------------------------------------------------------------
// bpsrch_pkg
// Types and constants of the byte pattern search block.
// ----------------------------------------------------------------------------
package bpsrch_pkg;

  // Longest pattern held in the cell row.
  localparam int PATTERN_MAX = 32;
  // Text position limit; later bytes cannot end a match.
  localparam int MAX_TEXT    = 65536;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 16;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W  = $clog2(MAX_TEXT + 1);

  // Request kinds on the input channel.
  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_e;

  // Compare stage contents, one item behind the cell row.
  typedef struct packed {
    logic                   text;
    logic                   last;
    logic                   qual;
    logic [PATTERN_MAX-1:0] eq;
    logic [OFF_W-1:0]       off;
  } cmp_stage_t;

endpackage

>>> src/bpsrch_if.sv
// ----------------------------------------------------------------------------
// bpsrch channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bpsrch_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bpsrch_pkg::BYTE_W-1:0] data_byte;
  logic                          last;

  modport source (output valid, output req_type, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input last,
                  output ready);
endinterface

interface bpsrch_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [bpsrch_pkg::OFF_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

>>> src/bpsrch_cell.sv
// ----------------------------------------------------------------------------
// bpsrch_cell
// One slot of the search row: a pattern byte and a text window byte, both
// shifted in from the neighbor, plus the byte compare for this slot.
// ----------------------------------------------------------------------------
module bpsrch_cell (
  input  logic                          clk_i,
  input  logic                          pat_shift_i,
  input  logic                          win_shift_i,
  input  logic                          in_use_i,
  input  logic [bpsrch_pkg::BYTE_W-1:0] pat_i,
  input  logic [bpsrch_pkg::BYTE_W-1:0] win_i,
  output logic [bpsrch_pkg::BYTE_W-1:0] pat_o,
  output logic [bpsrch_pkg::BYTE_W-1:0] win_o,
  output logic                          eq_o
);

  logic [bpsrch_pkg::BYTE_W-1:0] pat_q, pat_d;
  logic [bpsrch_pkg::BYTE_W-1:0] win_q, win_d;

  // Shift next values
  always_comb begin
    pat_d = pat_shift_i ? pat_i : pat_q;
    win_d = win_shift_i ? win_i : win_q;
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    win_q <= win_d;
  end

  // Compare the byte entering this slot; unused slots always agree
  assign eq_o  = !in_use_i || (win_i == pat_q);
  assign pat_o = pat_q;
  assign win_o = win_q;

endmodule

>>> src/byte_pattern_search.sv
// ----------------------------------------------------------------------------
// byte_pattern_search
// Finds the earliest occurrence of a loaded byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Usage: items on in_i carry req_type, data_byte and last. Pattern bytes
// (REQ_PATTERN) are loaded first, last flagging the final one; any pattern
// byte abandons a text in progress. Text bytes (REQ_TEXT) then stream in one
// per cycle while ready is high; the item with last set yields one result
// on out_o: found and match_offset (0 when not found). The pattern is kept
// across texts. Throughput: one item per cycle while ready is high.
// Each text byte shifts through a row of PATTERN_MAX cells that compare it
// with the stored pattern in the cycle it is taken; the flags are reduced in
// the next cycle from the compare stage, then registered as the result.
// Stall: the result waits in the output register; the block keeps taking
// items until a second result would need that register, then holds ready
// low until out_o takes the waiting result.
// Reset: rst_ni (async, active low) clears the pattern length, flags and the
// text counter; no pattern is loaded afterward, so searches report not found.
// ----------------------------------------------------------------------------
`include "byte_pattern_search_macros.svh"

module byte_pattern_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bpsrch_in_if.sink            in_i,
  bpsrch_out_if.source         out_o
);

  localparam int PMAX  = bpsrch_pkg::PATTERN_MAX;
  localparam int LEN_W = bpsrch_pkg::LEN_W;
  localparam int CNT_W = bpsrch_pkg::CNT_W;
  localparam int OFF_W = bpsrch_pkg::OFF_W;
  localparam int BW    = bpsrch_pkg::BYTE_W;

  // Control state
  logic [LEN_W-1:0] len_q, len_d;
  logic             too_long_q, too_long_d;
  logic             loading_q, loading_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             seen_q, seen_d;
  logic [OFF_W-1:0] first_q, first_d;
  logic             s2_valid_q, s2_valid_d;
  bpsrch_pkg::cmp_stage_t s2_q, s2_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [OFF_W-1:0] moff_q, moff_d;

  logic             accept, is_text, advance, s2_final, hit;
  logic             pat_shift, win_shift;
  logic [LEN_W-1:0] base_len;
  logic [CNT_W:0]   pos_inc;
  logic [PMAX-1:0]  in_use, eq_vec;
  logic [BW-1:0]    pat_chain [PMAX+1];
  logic [BW-1:0]    win_chain [PMAX+1];

  // Handshake
  assign s2_final = s2_valid_q && s2_q.text && s2_q.last;
  assign advance  = !s2_final || !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign accept   = in_i.valid && advance;
  assign is_text  = (in_i.req_type == bpsrch_pkg::REQ_TEXT);

  // Pattern length seen by an incoming pattern byte
  assign base_len  = loading_q ? len_q : '0;
  assign pat_shift = accept && !is_text && (base_len < LEN_W'(PMAX));
  assign win_shift = accept && is_text;
  assign pos_inc   = {1'b0, cnt_q} + (CNT_W+1)'(1);

  // Cell row
  assign pat_chain[0] = in_i.data_byte;
  assign win_chain[0] = in_i.data_byte;

  for (genvar k = 0; k < PMAX; k++) begin : g_cell
    assign in_use[k] = (LEN_W'(k) < len_q);
    bpsrch_cell u_cell (
      .clk_i       (clk_i),
      .pat_shift_i (pat_shift),
      .win_shift_i (win_shift),
      .in_use_i    (in_use[k]),
      .pat_i       (pat_chain[k]),
      .win_i       (win_chain[k]),
      .pat_o       (pat_chain[k+1]),
      .win_o       (win_chain[k+1]),
      .eq_o        (eq_vec[k])
    );
  end

  // Front: pattern length, text counter, compare stage fill
  always_comb begin
    len_d      = len_q;
    too_long_d = too_long_q;
    loading_d  = loading_q;
    cnt_d      = cnt_q;
    s2_valid_d = advance ? 1'b0 : s2_valid_q;
    s2_d       = s2_q;
    if (accept) begin
      s2_valid_d = 1'b1;
      s2_d.text  = is_text;
      s2_d.last  = in_i.last;
      s2_d.eq    = eq_vec;
      s2_d.off   = OFF_W'(pos_inc - (CNT_W+1)'(len_q));
      s2_d.qual  = (len_q != '0) && !too_long_q && (cnt_q < CNT_W'(bpsrch_pkg::MAX_TEXT))
                   && (pos_inc >= (CNT_W+1)'(len_q));
      if (is_text) begin
        loading_d = 1'b0;
        if (in_i.last) begin
          cnt_d = '0;
        end else if (cnt_q < CNT_W'(bpsrch_pkg::MAX_TEXT)) begin
          cnt_d = pos_inc[CNT_W-1:0];
        end
      end else begin
        cnt_d      = '0;
        loading_d  = !in_i.last;
        too_long_d = loading_q ? too_long_q : 1'b0;
        len_d      = base_len;
        if (base_len < LEN_W'(PMAX)) begin
          len_d = base_len + LEN_W'(1);
        end else begin
          too_long_d = 1'b1;
        end
      end
    end
  end

  // Compare stage: reduce flags, track first match, fill output register
  assign hit = s2_q.text && s2_q.qual && (&s2_q.eq) && !seen_q;

  always_comb begin
    seen_d      = seen_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_o.ready;
    found_d     = found_q;
    moff_d      = moff_q;
    if (s2_valid_q && advance) begin
      if (!s2_q.text) begin
        seen_d  = 1'b0;
        first_d = '0;
      end else if (s2_q.last) begin
        out_valid_d = 1'b1;
        found_d     = seen_q || hit;
        moff_d      = seen_q ? first_q : (hit ? s2_q.off : '0);
        seen_d      = 1'b0;
        first_d     = '0;
      end else if (hit) begin
        seen_d  = 1'b1;
        first_d = s2_q.off;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      too_long_q  <= 1'b0;
      loading_q   <= 1'b0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      first_q     <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      too_long_q  <= too_long_d;
      loading_q   <= loading_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      first_q     <= first_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s2_q    <= s2_d;
    found_q <= found_d;
    moff_q  <= moff_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = moff_q;

  // Checks
  `BPS_ASSERT_IMPL(a_too_long_full, too_long_q, len_q == LEN_W'(PMAX), "overlong flag set early")
  `BPS_ASSERT_NEXT(a_result_out, s2_final && advance, out_valid_q, "result lost")
  `BPS_ASSERT_IMPL(a_offset_zero, out_valid_q && !found_q, moff_q == '0, "offset without match")

endmodule
